[sv/koq_pkg.sv]
package koq_pkg;

    localparam int CMD_W       = 2;
    localparam int KEY_IN_W    = 16;
    localparam int HANDLE_W    = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_POP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

[sv/koq_ram.sv]
module koq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/keyed_ordered_queue_top.sv]
// Keyed ordered queue: up to CAPACITY key/handle pairs in insertion order.
// Append writes at the tail, or flags overflow when full; lookup, remove and pop scan
// from the head to the first match, and remove and pop then shift later entries down.
// in_stall holds from accept until the result is registered, so a new command is
// not taken before the last one is through; a stalled result delays the next one.
// Reset (rst_n, async low) empties the table; the RAM contents are not cleared.
module keyed_ordered_queue_top #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [koq_pkg::CMD_W-1:0]       cmd,
    input  logic [koq_pkg::KEY_IN_W-1:0]    key,
    input  logic [koq_pkg::HANDLE_W-1:0]    handle_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [koq_pkg::HANDLE_W-1:0]    handle_out,
    output logic                            overflow,
    output logic [koq_pkg::COUNT_OUT_W-1:0] count
);

    import koq_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = KEY_BITS + HANDLE_W;

    // Sequencer and item registers
    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [HANDLE_W-1:0]  hin_reg, hin_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;      // scan position, then shift pointer
    logic [CNT_W-1:0]     count_reg, count_next;

    // Result being built
    logic                 res_found_reg, res_found_next;
    logic [HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic                 res_ovf_reg, res_ovf_next;

    // Output register: decouples result delivery from the sequencer
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [HANDLE_W-1:0]    out_handle_reg, out_handle_next;
    logic                   out_ovf_reg, out_ovf_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    // RAM port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    // Shared compare unit and position arithmetic
    logic [KEY_BITS-1:0] rd_key;
    logic [HANDLE_W-1:0] rd_handle;
    logic                hit;
    logic [CNT_W-1:0]    idx_plus1;
    logic [CNT_W-1:0]    idx_plus2;
    logic                scan_more;
    logic                shift_more;
    logic                out_free;

    koq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key     = rd_data[HANDLE_W +: KEY_BITS];
    assign rd_handle  = rd_data[HANDLE_W-1:0];
    // pop always takes the head, so every read counts as a hit
    assign hit        = (cmd_reg == CMD_POP) || (rd_key == key_reg);
    assign idx_plus1  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_plus2  = CNT_W'(idx_reg) + CNT_W'(2);
    assign scan_more  = idx_plus1 < count_reg;
    assign shift_more = idx_plus2 < count_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign handle_out = out_handle_reg;
    assign overflow   = out_ovf_reg;
    assign count      = out_count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (cmd_reg == CMD_APPEND || count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg != CMD_LOOKUP && scan_more)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (!scan_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        hin_next        = hin_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_found_next  = res_found_reg;
        res_handle_next = res_handle_reg;
        res_ovf_next    = res_ovf_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_found_next  = out_found_reg;
        out_handle_next = out_handle_reg;
        out_ovf_next    = out_ovf_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;
        rd_addr         = IDX_W'(idx_plus1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd_t'(cmd);
                    key_next        = KEY_BITS'(key);
                    hin_next        = handle_in;
                    res_found_next  = 1'b0;
                    res_handle_next = '0;
                    res_ovf_next    = 1'b0;
                end
            end
            ST_START:
            begin
                if (cmd_reg == CMD_APPEND)
                begin
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(count_reg);
                        wr_data    = {key_reg, hin_reg};
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_ovf_next = 1'b1;
                    end
                end
                else
                begin
                    idx_next = '0;
                    rd_addr  = '0;
                end
            end
            ST_SCAN:
            begin
                // read of the next entry is already on its way; on a hit it feeds the shift
                if (hit)
                begin
                    res_found_next  = 1'b1;
                    res_handle_next = rd_handle;
                    if (cmd_reg != CMD_LOOKUP && !scan_more)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next = IDX_W'(idx_plus1);
                end
            end
            ST_SHIFT:
            begin
                // move entry idx+1 (just read) down to idx, fetch idx+2
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                rd_addr  = IDX_W'(idx_plus2);
                idx_next = IDX_W'(idx_plus1);
                if (!shift_more)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_handle_next = res_handle_reg;
                    out_ovf_next    = res_ovf_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        hin_reg        <= hin_next;
        idx_reg        <= idx_next;
        res_found_reg  <= res_found_next;
        res_handle_reg <= res_handle_next;
        res_ovf_reg    <= res_ovf_next;
        out_found_reg  <= out_found_next;
        out_handle_reg <= out_handle_next;
        out_ovf_reg    <= out_ovf_next;
        out_count_reg  <= out_count_next;
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for keyed_ordered_queue_top.
// Every accepted command is applied to a scoreboard copy of the table (keys,
// handles, count), which gives the expected result. Results are checked in
// order against the queue of expected results.
module tb_top;
    import koq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int KEY_BITS      = 16;
    // Worst-case service time: full scan + full shift, with margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 120;

    typedef struct packed {
        logic                   found;
        logic [HANDLE_W-1:0]    handle;
        logic                   overflow;
        logic [COUNT_OUT_W-1:0] count;
    } queue_result_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd        = '0;
    logic [KEY_IN_W-1:0]    key        = '0;
    logic [HANDLE_W-1:0]    handle_in  = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic                   found;
    logic [HANDLE_W-1:0]    handle_out;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] count;

    // Scoreboard copy of the table, oldest entry at index 0.
    logic [KEY_IN_W-1:0]    tbl_keys [CAPACITY];
    logic [HANDLE_W-1:0]    tbl_handles [CAPACITY];
    int                     tbl_count;

    queue_result_t          expected_results [$];
    logic [KEY_IN_W-1:0]    key_pool [8];

    // Idle rates in percent; the receiver process also honors a forced hold-off.
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    logic                   hold_off      = 1'b0;

    int                     errors        = 0;
    int                     n_sent        = 0;
    int                     n_checked     = 0;
    int                     n_overflow    = 0;
    int                     n_hits        = 0;
    int                     n_full        = 0;

    keyed_ordered_queue_top #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .key(key),
        .handle_in(handle_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .handle_out(handle_out),
        .overflow(overflow),
        .count(count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one command to the scoreboard table and return the result it gives.
    function automatic queue_result_t apply_queue_op(cmd_t op, logic [KEY_IN_W-1:0] k,
                                                     logic [HANDLE_W-1:0] h);
        queue_result_t r;
        int            pos;
        r   = '0;
        pos = -1;
        if (op == CMD_APPEND)
        begin
            if (tbl_count < CAPACITY)
            begin
                tbl_keys[tbl_count]    = k;
                tbl_handles[tbl_count] = h;
                tbl_count++;
            end
            else
                r.overflow = 1'b1;
        end
        else
        begin
            if (op == CMD_POP)
            begin
                if (tbl_count > 0)
                    pos = 0;
            end
            else
            begin
                // oldest match wins when keys repeat
                for (int i = 0; i < tbl_count; i++)
                    if (pos < 0 && tbl_keys[i] == k)
                        pos = i;
            end
            if (pos >= 0)
            begin
                r.found  = 1'b1;
                r.handle = tbl_handles[pos];
                if (op != CMD_LOOKUP)
                begin
                    // close the gap left by the removed entry
                    for (int i = pos; i < tbl_count - 1; i++)
                    begin
                        tbl_keys[i]    = tbl_keys[i + 1];
                        tbl_handles[i] = tbl_handles[i + 1];
                    end
                    tbl_count--;
                end
            end
        end
        r.count = tbl_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Offer one transaction; valid is left high on return so back-to-back
    // commands need no extra assignment. The scoreboard is updated on accept.
    task automatic offer_transaction(cmd_t op, logic [KEY_IN_W-1:0] k,
                                     logic [HANDLE_W-1:0] h);
        queue_result_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        key       <= k;
        handle_in <= h;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_queue_op(op, k, h);
        expected_results.push_back(r);
        n_sent++;
        if (r.overflow)
            n_overflow++;
        if (r.found)
            n_hits++;
        if (tbl_count == CAPACITY)
            n_full++;
    endtask

    // Sender pause: drop valid and let every outstanding result come back.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly keys already in the table, so lookups and removes hit.
    function automatic logic [KEY_IN_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (tbl_count > 0 && r < 55)
            return tbl_keys[$urandom_range(tbl_count - 1)];
        else if (r < 85)
            return key_pool[$urandom_range(7)];
        return KEY_IN_W'($urandom);
    endfunction

    function automatic cmd_t pick_cmd(bit fill_bias);
        int r;
        r = $urandom_range(99);
        if (fill_bias)
            return (r < 50) ? CMD_APPEND : (r < 70) ? CMD_LOOKUP :
                   (r < 85) ? CMD_REMOVE : CMD_POP;
        return (r < 20) ? CMD_APPEND : (r < 45) ? CMD_LOOKUP :
               (r < 75) ? CMD_REMOVE : CMD_POP;
    endfunction

    // Lookup, remove and pop with nothing stored.
    task automatic test_empty_table();
        offer_transaction(CMD_POP, 16'h0000, 32'h0);
        offer_transaction(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);
        offer_transaction(CMD_REMOVE, 16'h0000, 32'h0);
        wait_until_drained();
    endtask

    // Extreme keys and handles, a repeated key, a miss.
    task automatic test_duplicate_keys();
        offer_transaction(CMD_APPEND, 16'h0000, 32'h0000_0000);
        offer_transaction(CMD_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
        offer_transaction(CMD_APPEND, 16'h0000, 32'h1234_5678);
        offer_transaction(CMD_LOOKUP, 16'h0000, 32'h0);   // oldest of the pair
        offer_transaction(CMD_LOOKUP, 16'h5A5A, 32'h0);   // miss
        offer_transaction(CMD_REMOVE, 16'h0000, 32'h0);   // oldest goes, gap closes
        offer_transaction(CMD_LOOKUP, 16'h0000, 32'h0);   // now the younger one
        offer_transaction(CMD_POP, 16'h0000, 32'h0);
        wait_until_drained();
    endtask

    // Fill to capacity, then one append that must be dropped and a remove of the newest entry.
    task automatic test_full_table();
        while (tbl_count < CAPACITY)
            offer_transaction(CMD_APPEND, KEY_IN_W'($urandom), $urandom);
        offer_transaction(CMD_APPEND, 16'hA5A5, 32'hDEAD_BEEF);
        offer_transaction(CMD_REMOVE, tbl_keys[CAPACITY-1], 32'h0); // deepest scan
        wait_until_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block backs up and stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (12)
                    offer_transaction(pick_cmd(1'b1), pick_key(), $urandom);
            end
        join
        wait_until_drained();
    endtask

    // Random commands; the bias flips between filling and draining the table
    // so that both full and empty are reached often.
    task automatic test_random(int n_items, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < n_items; n++)
            offer_transaction(pick_cmd(((n / 25) % 2) == 0), pick_key(), $urandom);
        wait_until_drained();
    endtask

    // Receiver: random stall, forced high during a hold-off.
    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: found=%0b handle=%h overflow=%0b count=%0d",
                       found, handle_out, overflow, count);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (found !== want.found)
                begin
                    $error("found: expected %0b actual %0b", want.found, found);
                    errors++;
                end
                if (handle_out !== want.handle)
                begin
                    $error("handle_out: expected %h actual %h", want.handle, handle_out);
                    errors++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b actual %0b", want.overflow, overflow);
                    errors++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d actual %0d", want.count, count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        tbl_count = 0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = KEY_IN_W'($urandom);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 30;
        test_empty_table();
        test_duplicate_keys();
        test_full_table();
        test_backpressure();
        test_random(150, 24, 88);
        test_random(150, 88, 24);
        test_random(150, 0, 0);

        $display("summary: %0d transactions, %0d results checked, %0d hits, %0d dropped appends",
                 n_sent, n_checked, n_hits, n_overflow);
        $display("summary: table full after %0d transactions; idle mixes and a long hold-off",
                 n_full);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
